>>> rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Types, constants and alphabet functions shared by the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CountW     = 3;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic       MODE_ENC   = 1'b0;
    localparam logic       MODE_DEC   = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    typedef struct packed {
        logic [CountW-1:0]               count;
        logic [MaxResults-1:0][7:0]      data;
    } res_t;

    function automatic logic [7:0] to_char(input logic [5:0] s);
        logic [7:0] c;
        begin
            if (s < 6'd26)
            begin
                c = 8'h41 + {2'b00, s};
            end
            else if (s < 6'd52)
            begin
                c = 8'h61 + {2'b00, s} - 8'd26;
            end
            else if (s < 6'd62)
            begin
                c = 8'h30 + {2'b00, s} - 8'd52;
            end
            else if (s == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

    function automatic sextet_t to_sextet(input logic [7:0] c);
        sextet_t r;
        logic [7:0] t;
        begin
            r = '0;
            t = '0;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                t = c - 8'h41;
                r = '{ok: 1'b1, val: t[5:0]};
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                t = c - 8'h61 + 8'd26;
                r = '{ok: 1'b1, val: t[5:0]};
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                t = c - 8'h30 + 8'd52;
                r = '{ok: 1'b1, val: t[5:0]};
            end
            else if (c == 8'h2B)
            begin
                r = '{ok: 1'b1, val: 6'd62};
            end
            else if (c == 8'h2F)
            begin
                r = '{ok: 1'b1, val: 6'd63};
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/b64_if.sv
// ----------------------------------------------------------------------------
// b64_if
// Valid/ready stream interfaces for the codec input and result channels.
// ----------------------------------------------------------------------------
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/b64_core.sv
// ----------------------------------------------------------------------------
// b64_core
// Mode register, group state and the single-pass encode/decode logic.
// ----------------------------------------------------------------------------
module b64_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mode_we,
    input  logic          mode_wdata,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output b64_pkg::res_t res
);
    import b64_pkg::*;

    logic        mode_reg;
    logic [1:0]  pos_reg,  pos_next;
    logic [15:0] held_reg, held_next;
    logic        stop_reg, stop_next;

    logic [23:0] w;
    logic [15:0] h2;
    sextet_t     sx;

    always_comb
    begin
        res       = '0;
        pos_next  = pos_reg;
        held_next = held_reg;
        stop_next = stop_reg;
        w         = {held_reg, in_byte};
        h2        = {held_reg[7:0], in_byte};
        sx        = to_sextet(in_byte);

        if (mode_reg == MODE_ENC)
        begin
            case (pos_reg)
                2'd0:
                begin
                    held_next = {8'h00, in_byte};
                    pos_next  = 2'd1;
                    if (in_last)
                    begin
                        res.count   = CountW'(MaxResults);
                        res.data[0] = to_char(in_byte[7:2]);
                        res.data[1] = to_char({in_byte[1:0], 4'b0000});
                        res.data[2] = PAD_CHAR;
                        res.data[3] = PAD_CHAR;
                    end
                end
                2'd1:
                begin
                    held_next = h2;
                    pos_next  = 2'd2;
                    if (in_last)
                    begin
                        res.count   = CountW'(MaxResults);
                        res.data[0] = to_char(h2[15:10]);
                        res.data[1] = to_char(h2[9:4]);
                        res.data[2] = to_char({h2[3:0], 2'b00});
                        res.data[3] = PAD_CHAR;
                    end
                end
                default:
                begin
                    held_next   = '0;
                    pos_next    = 2'd0;
                    res.count   = CountW'(MaxResults);
                    res.data[0] = to_char(w[23:18]);
                    res.data[1] = to_char(w[17:12]);
                    res.data[2] = to_char(w[11:6]);
                    res.data[3] = to_char(w[5:0]);
                end
            endcase
        end
        else if (!stop_reg)
        begin
            if (!sx.ok)
            begin
                stop_next = 1'b1;
            end
            else
            begin
                case (pos_reg)
                    2'd0:
                    begin
                        held_next = {10'd0, sx.val};
                        pos_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        res.count   = CountW'(1);
                        res.data[0] = {held_reg[5:0], sx.val[5:4]};
                        held_next   = {12'd0, sx.val[3:0]};
                        pos_next    = 2'd2;
                    end
                    2'd2:
                    begin
                        res.count   = CountW'(1);
                        res.data[0] = {held_reg[3:0], sx.val[5:2]};
                        held_next   = {14'd0, sx.val[1:0]};
                        pos_next    = 2'd3;
                    end
                    default:
                    begin
                        res.count   = CountW'(1);
                        res.data[0] = {held_reg[1:0], sx.val};
                        held_next   = '0;
                        pos_next    = 2'd0;
                    end
                endcase
            end
        end

        if (in_last)
        begin
            pos_next  = '0;
            held_next = '0;
            stop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENC;
            pos_reg  <= '0;
            held_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_wdata;
            pos_reg  <= '0;
            held_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
            stop_reg <= stop_next;
        end
    end

endmodule

>>> rtl/b64_out_buf.sv
// ----------------------------------------------------------------------------
// b64_out_buf
// Result register holding up to four bytes, shifted out one per transaction.
// ----------------------------------------------------------------------------
module b64_out_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  b64_pkg::res_t res,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last
);
    import b64_pkg::*;

    logic [CountW-1:0]          rem_reg,  rem_next;
    logic [MaxResults-1:0][7:0] data_reg, data_next;
    logic                       take;
    logic                       load;

    assign out_valid = (rem_reg != '0);
    assign out_byte  = data_reg[0];
    assign out_last  = (rem_reg == CountW'(1));
    assign take      = out_valid && out_ready;
    assign in_ready  = (rem_reg == '0) || (out_last && out_ready);
    assign load      = in_valid && in_ready;

    always_comb
    begin
        rem_next  = rem_reg;
        data_next = data_reg;
        if (load)
        begin
            rem_next  = res.count;
            data_next = res.data;
        end
        else if (take)
        begin
            rem_next = rem_reg - CountW'(1);
            for (int i = 0; i < MaxResults - 1; i++)
            begin
                data_next[i] = data_reg[i + 1];
            end
            data_next[MaxResults-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder and decoder with a standard alphabet and padding.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload              Handshake
// in_ch     sink       in_byte, in_last     valid / ready
// out_ch    source     out_byte, out_last   valid / ready
// mode      write      mode_wdata           mode_we
//
// An input transaction is processed in the cycle it is accepted and its
// results appear on out_ch in the next cycle, one per cycle while it is ready.
// A new input is taken whenever the result register is empty or its last
// result leaves in the same cycle, so the output port sets the pace: decode
// runs at one byte per cycle and encode takes no byte while a group's four
// results wait. Reset sets encode mode, clears group state; no clearing pass.
// ----------------------------------------------------------------------------
module base64_stream_codec
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mode_we,
    input  logic      mode_wdata,
    b64_in_if.sink    in_ch,
    b64_out_if.source out_ch
);
    import b64_pkg::*;

    res_t res;
    logic accept;

    assign accept = in_ch.valid && in_ch.ready;

    b64_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .accept     (accept),
        .in_byte    (in_ch.in_byte),
        .in_last    (in_ch.in_last),
        .res        (res)
    );

    b64_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .out_last  (out_ch.out_last)
    );

endmodule

>>> rtl/b64_codec_checker.sv
// ----------------------------------------------------------------------------
// b64_codec_props
// Port-level assertions for the base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64_codec_props
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result valid dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
        else $error("Result payload changed while stalled.");

    a_in_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready && out_last)
        else $error("Input accepted while earlier results were pending.");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last && !(in_valid && in_ready) |=> !out_valid)
        else $error("Results appeared without an input transaction.");

endmodule

bind base64_stream_codec b64_codec_props u_b64_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
);
